### rtl/mhpq_pkg.sv
`timescale 1ns / 1ps
// Shared types and codes for the max-heap priority queue.
// No dependencies; imported by the controller, datapath and top level.
package mhpq_pkg;

   localparam logic [1:0] KIND_INSERT  = 2'd0;
   localparam logic [1:0] KIND_EXTRACT = 2'd1;
   localparam logic [1:0] KIND_DRAIN   = 2'd2;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   // controller -> datapath
   typedef struct packed {
      logic       ins_start;   // load value, open hole at count, count++
      logic       take_start;  // read root and last entry, count--
      logic       take_latch;  // capture root and last entry, hole at root
      logic       up_read;     // read parent of hole
      logic       up_step;     // move parent down or settle value
      logic       up_root;     // hole reached root: settle value
      logic       down_read;   // read both children of hole
      logic       down_step;   // move larger child up or settle value
      logic       emit;        // load the output register
      logic       emit_top;    // word carries the extracted root
      logic       emit_last;
      logic [1:0] emit_code;
   } mhpq_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic empty;
      logic pos_zero;
      logic up_move;
      logic down_done;
      logic out_free;
   } mhpq_stat_type;

endpackage

### rtl/mhpq_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the max-heap queue: decodes requests and steps sift-up,
// sift-down and the drain loop. Depends on mhpq_pkg.
module mhpq_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [1:0]             req_kind,
   output logic                   req_stall,
   input  mhpq_pkg::mhpq_stat_type stat,
   output mhpq_pkg::mhpq_cmd_type  cmd
);
   import mhpq_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_UP,
      S_UP_CMP,
      S_TAKE,
      S_DOWN,
      S_DOWN_CMP,
      S_EMIT
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] code_ff, code_in;
   logic       top_ff, top_in;
   logic       drain_ff, drain_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      top_in   = top_ff;
      drain_in = drain_ff;
      cmd      = '0;
      cmd.emit_code = code_ff;
      cmd.emit_top  = top_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_kind)
                  KIND_INSERT: begin
                     top_in   = 1'b0;
                     drain_in = 1'b0;
                     if (stat.full) begin
                        code_in  = ST_FULL;
                        state_in = S_EMIT;
                     end else begin
                        code_in       = ST_OK;
                        cmd.ins_start = 1'b1;
                        state_in      = S_UP;
                     end
                  end
                  KIND_EXTRACT, KIND_DRAIN: begin
                     if (stat.empty) begin
                        code_in  = ST_EMPTY;
                        top_in   = 1'b0;
                        drain_in = 1'b0;
                        state_in = S_EMIT;
                     end else begin
                        code_in        = ST_OK;
                        top_in         = 1'b1;
                        drain_in       = (req_kind == KIND_DRAIN);
                        cmd.take_start = 1'b1;
                        state_in       = S_TAKE;
                     end
                  end
                  default: ;  // unused code: word dropped
               endcase
            end
         end
         S_UP: begin
            if (stat.pos_zero) begin
               cmd.up_root = 1'b1;
               state_in    = S_EMIT;
            end else begin
               cmd.up_read = 1'b1;
               state_in    = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            cmd.up_step = 1'b1;
            state_in    = stat.up_move ? S_UP : S_EMIT;
         end
         S_TAKE: begin
            cmd.take_latch = 1'b1;
            state_in       = S_DOWN;
         end
         S_DOWN: begin
            cmd.down_read = 1'b1;
            state_in      = S_DOWN_CMP;
         end
         S_DOWN_CMP: begin
            cmd.down_step = 1'b1;
            state_in      = stat.down_done ? S_EMIT : S_DOWN;
         end
         S_EMIT: begin
            if (stat.out_free) begin
               cmd.emit      = 1'b1;
               cmd.emit_last = !(drain_ff && !stat.empty);
               // drain: start the next take in the same cycle
               if (drain_ff && !stat.empty) begin
                  cmd.take_start = 1'b1;
                  state_in       = S_TAKE;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         code_ff  <= ST_OK;
         top_ff   <= 1'b0;
         drain_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
         top_ff   <= top_in;
         drain_ff <= drain_in;
      end
   end

endmodule

### rtl/mhpq_dpath.sv
`timescale 1ns / 1ps
// Heap store, entry count, hole pointer, compare logic and output register.
// Depends on mhpq_pkg; driven by mhpq_ctrl.
module mhpq_dpath #(
   parameter int DEPTH = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic signed [31:0]                  req_value,
   input  mhpq_pkg::mhpq_cmd_type               cmd,
   output mhpq_pkg::mhpq_stat_type              stat,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [31:0]                  rsp_result_value,
   output logic [1:0]                          rsp_status,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_count_after,
   output logic                                rsp_last
);
   import mhpq_pkg::*;

   localparam int AW  = $clog2(DEPTH);
   localparam int CW  = $clog2(DEPTH + 1);
   localparam int XW  = AW + 2;  // child index, up to 2*DEPTH
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   logic signed [31:0] heap_mem [DEPTH];

   logic [CW-1:0]      count_ff, count_in;
   logic [AW-1:0]      pos_ff, pos_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] top_ff, top_in;
   logic signed [31:0] rda_ff, rdb_ff;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_value_ff;
   logic [1:0]         rsp_status_ff;
   logic [CW-1:0]      rsp_count_ff;
   logic               rsp_last_ff;

   logic [AW-1:0]      rd_a_addr, rd_b_addr, parent, last_addr;
   logic [XW-1:0]      left_idx, right_idx, count_x;
   logic               left_ok, right_ok, big_left, big_right;
   logic signed [31:0] big_val, child_val;
   logic [XW-1:0]      child_idx;
   logic               wr_en;
   logic [AW-1:0]      wr_addr;
   logic signed [31:0] wr_data;
   logic               out_free;

   assign parent    = AW'((pos_ff - AW'(1)) >> 1);
   assign left_idx  = {1'b0, pos_ff, 1'b1};
   assign right_idx = left_idx + XW'(1);
   assign count_x   = XW'(count_ff);
   assign last_addr = AW'(count_ff - CW'(1));

   // sift-down choice: larger child, left wins a tie, move only past strictly smaller
   assign left_ok   = (left_idx < count_x);
   assign right_ok  = (right_idx < count_x);
   assign big_left  = left_ok && (val_ff < rda_ff);
   assign big_val   = big_left ? rda_ff : val_ff;
   assign big_right = right_ok && (big_val < rdb_ff);
   assign child_val = big_right ? rdb_ff : rda_ff;
   assign child_idx = big_right ? right_idx : left_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   assign stat.full      = (count_ff == FULL_COUNT);
   assign stat.empty     = (count_ff == '0);
   assign stat.pos_zero  = (pos_ff == '0);
   assign stat.up_move   = (rda_ff < val_ff);
   assign stat.down_done = !big_left && !big_right;
   assign stat.out_free  = out_free;

   always_comb begin
      rd_a_addr = '0;
      rd_b_addr = last_addr;
      if (cmd.up_read) begin
         rd_a_addr = parent;
      end else if (cmd.down_read) begin
         rd_a_addr = left_idx[AW-1:0];
         rd_b_addr = right_idx[AW-1:0];
      end
   end

   always_comb begin
      wr_en   = cmd.up_root || cmd.up_step || cmd.down_step;
      wr_addr = pos_ff;
      wr_data = val_ff;
      if (cmd.up_step && stat.up_move) begin
         wr_data = rda_ff;
      end else if (cmd.down_step && !stat.down_done) begin
         wr_data = child_val;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      rda_ff <= heap_mem[rd_a_addr];
      rdb_ff <= heap_mem[rd_b_addr];
   end

   always_comb begin
      count_in = count_ff;
      pos_in   = pos_ff;
      val_in   = val_ff;
      top_in   = top_ff;
      if (cmd.ins_start) begin
         val_in   = req_value;
         pos_in   = AW'(count_ff);
         count_in = count_ff + CW'(1);
      end
      if (cmd.take_start) begin
         count_in = count_ff - CW'(1);
      end
      if (cmd.take_latch) begin
         top_in = rda_ff;
         val_in = rdb_ff;
         pos_in = '0;
      end
      if (cmd.up_step && stat.up_move) begin
         pos_in = parent;
      end
      if (cmd.down_step && !stat.down_done) begin
         pos_in = child_idx[AW-1:0];
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff <= pos_in;
      val_ff <= val_in;
      top_ff <= top_in;
      if (cmd.emit) begin
         rsp_value_ff  <= cmd.emit_top ? top_ff : 32'sd0;
         rsp_status_ff <= cmd.emit_code;
         rsp_count_ff  <= count_ff;
         rsp_last_ff   <= cmd.emit_last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_count_after  = rsp_count_ff;
   assign rsp_last         = rsp_last_ff;

endmodule

### rtl/max_heap_priority_queue.sv
`timescale 1ns / 1ps
// Binary max-heap priority queue of signed 32-bit words, up to DEPTH entries,
// held in a single memory with one write and two registered read ports.
// Handles one request at a time, staying busy until its word is emitted. An insert
// reads the parent of the hole and compares, once per level the new word climbs;
// an extract latches the root and last entry, then reads both children of the hole
// and compares, once per level the moved word sinks. The walk is paced by the
// read-compare-write loop of the heap, and a stalled output holds the queue busy.
// A drain gives one word per extracted entry, with last set on the final one. The
// output register lets a finished word wait while the next request is taken.
// Reset clears only the entry count, the output valid flag and the control state;
// no memory clearing pass is needed.
module max_heap_priority_queue #(
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [1:0]                 req_kind,
   input  logic signed [31:0]         req_value,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [31:0]         rsp_result_value,
   output logic [1:0]                 rsp_status,
   output logic [$clog2(DEPTH+1)-1:0] rsp_count_after,
   output logic                       rsp_last
);
   import mhpq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

   mhpq_cmd_type  cmd;
   mhpq_stat_type stat;

   mhpq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   mhpq_dpath #(
      .DEPTH (DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .req_value        (req_value),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_value (rsp_result_value),
      .rsp_status       (rsp_status),
      .rsp_count_after  (rsp_count_after),
      .rsp_last         (rsp_last)
   );

`ifndef ASSERT_OFF
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_FULL) |->
         (rsp_count_after == FULL_COUNT && rsp_last && rsp_result_value == 32'sd0))
      else $error("full word with bad count or payload");

   a_empty_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |->
         (rsp_count_after == '0 && rsp_last && rsp_result_value == 32'sd0))
      else $error("empty word with bad count or payload");

   a_drain_mid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_status == ST_OK && rsp_count_after != '0))
      else $error("drain word not last while heap is empty");

   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && cmd.take_start) |-> (!stat.empty && !cmd.emit_last))
      else $error("drain continued on an empty heap");
`endif

endmodule
